### src/frustum_sphere_cull_test_macros.svh
// Assertion shorthands used by the RTL; clk and rst_n come from the using module.
`ifndef FRUSTUM_SPHERE_CULL_TEST_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_TEST_MACROS_SVH

// Same-cycle implication.
`define FSCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fsct_pkg.sv
package fsct_pkg;

    localparam int INT_BITS         = 14;
    localparam int NORMAL_BITS      = 14;
    localparam int NORMAL_FRAC_BITS = 12;
    localparam int OFFSET_BITS      = 22;
    localparam int PLANE_COUNT      = 6;
    localparam int PLANE_BITS       = 64;
    localparam int TOL_RESET_UNITS  = 5;
    localparam int APB_ADDR_W       = 6;
    localparam int REG_STRIDE_LOG2  = 3;
    localparam int REG_IDX_W        = APB_ADDR_W - REG_STRIDE_LOG2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PLANE_TOP    = 3'd0,
        REG_PLANE_BOTTOM = 3'd1,
        REG_PLANE_NEAR   = 3'd2,
        REG_PLANE_FAR    = 3'd3,
        REG_PLANE_LEFT   = 3'd4,
        REG_PLANE_RIGHT  = 3'd5,
        REG_TOLERANCE    = 3'd6
    } reg_idx_t;

    // Plane register layout, two's complement fields
    typedef struct packed {
        logic [OFFSET_BITS-1:0] d;
        logic [NORMAL_BITS-1:0] c;
        logic [NORMAL_BITS-1:0] b;
        logic [NORMAL_BITS-1:0] a;
    } plane_t;

    typedef struct packed {
        logic valid;
        logic outside;
    } cell_ctl_t;

endpackage

### src/fsct_if.sv
interface fsct_query_if
    import fsct_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) ();
    localparam int COORD_W = INT_BITS + FRACTION_BITS;
    localparam int SIZE_W  = INT_BITS - 1 + FRACTION_BITS;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [SIZE_W-1:0]         sphere_radius;

    modport source (output valid, pos_x, pos_y, pos_z, sphere_radius, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, sphere_radius, output ready);
endinterface

interface fsct_verdict_if ();
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink (input valid, inside_res, output ready);
endinterface

### src/fsct_cell.sv
module fsct_cell
    import fsct_pkg::*;
#(
    parameter int FRACTION_BITS = 8,
    localparam int COORD_W = INT_BITS + FRACTION_BITS,
    localparam int LIM_W   = INT_BITS + FRACTION_BITS,
    localparam int PROD_W  = NORMAL_BITS + COORD_W,
    localparam int SUM_W   = PROD_W + 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic                      plane_we,
    input  logic [PLANE_BITS-1:0]     plane_wdata,
    output plane_t                    plane,
    input  cell_ctl_t                 up_ctl,
    input  logic signed [COORD_W-1:0] up_x,
    input  logic signed [COORD_W-1:0] up_y,
    input  logic signed [COORD_W-1:0] up_z,
    input  logic [LIM_W-1:0]          up_limit,
    output cell_ctl_t                 dn_ctl,
    output logic signed [COORD_W-1:0] dn_x,
    output logic signed [COORD_W-1:0] dn_y,
    output logic signed [COORD_W-1:0] dn_z,
    output logic [LIM_W-1:0]          dn_limit
);

    plane_t                    plane_reg;
    cell_ctl_t                 ctl1_reg;
    cell_ctl_t                 ctl2_reg;
    cell_ctl_t                 ctl2_next;
    logic signed [PROD_W-1:0]  ax_reg, by_reg, cz_reg;
    logic signed [PROD_W-1:0]  ax_next, by_next, cz_next;
    logic [OFFSET_BITS-1:0]    d_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg, z1_reg;
    logic signed [COORD_W-1:0] x2_reg, y2_reg, z2_reg;
    logic [LIM_W-1:0]          lim1_reg, lim2_reg;
    logic signed [NORMAL_BITS-1:0] coef_a, coef_b, coef_c;
    logic signed [SUM_W-1:0]   d_term;
    logic signed [SUM_W-1:0]   lim_term;
    logic signed [SUM_W-1:0]   plane_dist;

    assign coef_a = $signed(plane_reg.a);
    assign coef_b = $signed(plane_reg.b);
    assign coef_c = $signed(plane_reg.c);

    // Stage 1: three products in parallel
    assign ax_next = PROD_W'(coef_a) * PROD_W'(up_x);
    assign by_next = PROD_W'(coef_b) * PROD_W'(up_y);
    assign cz_next = PROD_W'(coef_c) * PROD_W'(up_z);

    // Stage 2: align offset and limit to the product format, sum and compare
    assign d_term     = $signed({{(SUM_W - OFFSET_BITS - NORMAL_FRAC_BITS){d_reg[OFFSET_BITS-1]}},
                                 d_reg, {NORMAL_FRAC_BITS{1'b0}}});
    assign lim_term   = $signed({{(SUM_W - LIM_W - NORMAL_FRAC_BITS){1'b0}},
                                 lim1_reg, {NORMAL_FRAC_BITS{1'b0}}});
    assign plane_dist = SUM_W'(ax_reg) + SUM_W'(by_reg) + SUM_W'(cz_reg) + d_term;

    always_comb
    begin
        ctl2_next.valid   = ctl1_reg.valid;
        ctl2_next.outside = ctl1_reg.outside | (plane_dist > lim_term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
        end
        else
        begin
            if (plane_we)
            begin
                plane_reg <= plane_t'(plane_wdata);
            end
            if (advance)
            begin
                ctl1_reg <= up_ctl;
                ctl2_reg <= ctl2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg   <= ax_next;
            by_reg   <= by_next;
            cz_reg   <= cz_next;
            d_reg    <= plane_reg.d;
            x1_reg   <= up_x;
            y1_reg   <= up_y;
            z1_reg   <= up_z;
            lim1_reg <= up_limit;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
            lim2_reg <= lim1_reg;
        end
    end

    assign plane    = plane_reg;
    assign dn_ctl   = ctl2_reg;
    assign dn_x     = x2_reg;
    assign dn_y     = y2_reg;
    assign dn_z     = z2_reg;
    assign dn_limit = lim2_reg;

endmodule

### src/frustum_sphere_cull_test.sv
// Six-plane frustum culling for a sphere (radius 0 tests a point). Accepts one
// transaction per clock while no verdict is stalled and returns one verdict per
// transaction, in order: one entry register forms radius plus tolerance, then
// the item walks a chain of six plane cells, each with a multiply stage and a
// sum-and-compare stage, and the last cell's register is the output register.
// The whole chain holds while a verdict waits to be taken. Plane registers sit
// at byte offsets 0x00 to 0x28 (top, bottom, near, far, left, right; a in bits
// 13:0, b in 27:14, c in 41:28, d in 63:42), tolerance at 0x30; write them only
// while no transaction is in flight.
module frustum_sphere_cull_test
    import fsct_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    fsct_query_if.sink            query,
    fsct_verdict_if.source        verdict,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [PLANE_BITS-1:0] pwdata,
    output logic [PLANE_BITS-1:0] prdata,
    output logic                  pready
);

`include "frustum_sphere_cull_test_macros.svh"

    localparam int COORD_W = INT_BITS + FRACTION_BITS;
    localparam int SIZE_W  = INT_BITS - 1 + FRACTION_BITS;
    localparam int LIM_W   = SIZE_W + 1;

    logic                      cfg_wr;
    reg_idx_t                  reg_sel;
    logic [SIZE_W-1:0]         tol_reg;
    logic                      advance;
    cell_ctl_t                 ctl0_reg;
    logic signed [COORD_W-1:0] x0_reg, y0_reg, z0_reg;
    logic [LIM_W-1:0]          lim0_reg;
    logic [LIM_W-1:0]          lim0_next;
    plane_t                    plane_rd [PLANE_COUNT];
    cell_ctl_t                 link_ctl [PLANE_COUNT+1];
    logic signed [COORD_W-1:0] link_x   [PLANE_COUNT+1];
    logic signed [COORD_W-1:0] link_y   [PLANE_COUNT+1];
    logic signed [COORD_W-1:0] link_z   [PLANE_COUNT+1];
    logic [LIM_W-1:0]          link_lim [PLANE_COUNT+1];

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:REG_STRIDE_LOG2]);

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel) inside
            REG_PLANE_TOP, REG_PLANE_BOTTOM, REG_PLANE_NEAR,
            REG_PLANE_FAR, REG_PLANE_LEFT, REG_PLANE_RIGHT:
                prdata = plane_rd[paddr[APB_ADDR_W-1:REG_STRIDE_LOG2]];
            REG_TOLERANCE:
                prdata = PLANE_BITS'(tol_reg);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= SIZE_W'(TOL_RESET_UNITS) << FRACTION_BITS;
        end
        else if (cfg_wr && reg_sel == REG_TOLERANCE)
        begin
            tol_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // Whole chain advances unless the output register is full and stalled
    assign advance     = !verdict.valid || verdict.ready;
    assign query.ready = advance;

    assign lim0_next = LIM_W'(query.sphere_radius) + LIM_W'(tol_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (advance)
        begin
            ctl0_reg.valid   <= query.valid;
            ctl0_reg.outside <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x0_reg   <= query.pos_x;
            y0_reg   <= query.pos_y;
            z0_reg   <= query.pos_z;
            lim0_reg <= lim0_next;
        end
    end

    assign link_ctl[0] = ctl0_reg;
    assign link_x[0]   = x0_reg;
    assign link_y[0]   = y0_reg;
    assign link_z[0]   = z0_reg;
    assign link_lim[0] = lim0_reg;

    for (genvar i = 0; i < PLANE_COUNT; i++)
    begin : g_cell
        fsct_cell #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .plane_we    (cfg_wr && (paddr[APB_ADDR_W-1:REG_STRIDE_LOG2] == REG_IDX_W'(i))),
            .plane_wdata (pwdata),
            .plane       (plane_rd[i]),
            .up_ctl      (link_ctl[i]),
            .up_x        (link_x[i]),
            .up_y        (link_y[i]),
            .up_z        (link_z[i]),
            .up_limit    (link_lim[i]),
            .dn_ctl      (link_ctl[i+1]),
            .dn_x        (link_x[i+1]),
            .dn_y        (link_y[i+1]),
            .dn_z        (link_z[i+1]),
            .dn_limit    (link_lim[i+1])
        );
    end

    assign verdict.valid      = link_ctl[PLANE_COUNT].valid;
    assign verdict.inside_res = !link_ctl[PLANE_COUNT].outside;

    `FSCT_ASSERT_NOW(a_stall_backs_up, verdict.valid && !verdict.ready, !query.ready,
        "input accepted while a verdict is stalled")
    `FSCT_ASSERT_NEXT(a_accept_enters, query.valid && query.ready, ctl0_reg.valid,
        "accepted transaction missing from entry stage")
    `FSCT_ASSERT_NEXT(a_tol_write, cfg_wr && reg_sel == REG_TOLERANCE,
        tol_reg == $past(pwdata[SIZE_W-1:0]), "tolerance write lost")

endmodule
